// File: design/aws_pkg.sv
// Package with the shared constants and types of the angle window speed block.
`default_nettype none

package aws_pkg;

  localparam int WINDOW     = 20;
  localparam int ANGLE_W    = 9;
  localparam int PERIOD_W   = 10;
  localparam int SPEED_W    = 15;
  localparam int SCALE      = 1000;
  localparam int PERIOD_RST = 10;
  localparam int SPEED_MAX  = 32767;

  localparam int COUNT_W = $clog2(WINDOW + 1);
  localparam int SCAN_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  // Numerator is the largest spread times the scale factor.
  localparam int NUM_W   = $clog2(((1 << ANGLE_W) - 1) * SCALE + 1);
  // Denominator is the window length times the largest period.
  localparam int DEN_W   = $clog2(WINDOW * ((1 << PERIOD_W) - 1) + 1);
  localparam int STEP_W  = $clog2(NUM_W + 1);

  typedef logic [ANGLE_W-1:0] angle_t;

  typedef struct packed {
    angle_t lo;
    angle_t hi;
  } minmax_t;

endpackage : aws_pkg

`default_nettype wire

// File: design/aws_cell.sv
// One cell of the sample chain: holds a sample and folds it into the passing min/max pair.
`default_nettype none

module aws_cell (
  input  wire logic            clk,
  input  wire logic            shift_en,
  input  wire aws_pkg::angle_t din,
  input  wire aws_pkg::minmax_t mm_in,
  output aws_pkg::angle_t      sample,
  output aws_pkg::minmax_t     mm_out
);
  import aws_pkg::*;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sample <= din;
    end
    mm_out.lo <= (sample < mm_in.lo) ? sample : mm_in.lo;
    mm_out.hi <= (sample > mm_in.hi) ? sample : mm_in.hi;
  end

endmodule : aws_cell

`default_nettype wire

// File: design/aws_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module aws_divider (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [aws_pkg::NUM_W-1:0] num,
  input  wire logic [aws_pkg::DEN_W-1:0] den,
  output logic [aws_pkg::NUM_W-1:0]     quotient,
  output logic                          done
);
  import aws_pkg::*;

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  divisor;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem, quotient[NUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      divisor  <= den;
      quotient <= num;
    end else if (busy) begin
      // The remainder stays below the divisor, so it always fits DEN_W bits.
      rem      <= fits ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
      quotient <= {quotient[NUM_W-2:0], fits};
    end
  end

endmodule : aws_divider

`default_nettype wire

// File: design/angle_window_speed_top.sv
// Top level of the angle window speed block: sample chain, control and divider.
//
// Each input transfer carries one angle sample, which shifts into a chain of WINDOW
// cells; a set restart flag clears the sample count before the sample counts. Until
// WINDOW samples are held the result (speed 0, not valid) goes straight to the done
// state and from there into the output register. With a full window a min/max pair
// ripples down the chain, one cell per cycle, while the scan state waits for the spread;
// it is scaled by 1000 and divided by WINDOW times the sample period in a restoring
// divider that makes one quotient bit per cycle. The result then passes the scan,
// multiply, divide and done states into the output register, and the next sample is
// taken only after that; a result that waits for a previous one still held in the output
// register stalls in the done state.
// One item is worked on at a time; the next sample is taken while a finished result
// still waits in the output register.
// A sample period of 0 is used as 1, and speeds above 32767 saturate.
`default_nettype none

module angle_window_speed_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [9:0]  cfg_wdata,   // sample_period_ms
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,     // [8:0] angle, [15:9] zero
  input  wire logic        s_tuser,     // [0] restart
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,     // [14:0] speed, [15] zero
  output logic             m_tuser      // [0] speed_valid
);
  import aws_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]          state;
  logic [PERIOD_W-1:0] period;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  logic [SCAN_W-1:0]   scan;
  logic [DEN_W-1:0]    den;
  logic [SPEED_W-1:0]  speed_r;
  logic                speed_valid_r;
  logic                accept;
  logic                out_free;

  angle_t  chain_sample [WINDOW];
  minmax_t chain_mm     [WINDOW+1];

  logic [ANGLE_W-1:0] spread;
  logic [NUM_W-1:0]   num;
  logic [NUM_W-1:0]   quotient;
  logic               div_done;
  logic [PERIOD_W-1:0] period_eff;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // The chain: cell 0 takes the new sample, each other cell its left neighbor's.
  assign chain_mm[0].lo = '1;
  assign chain_mm[0].hi = '0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    aws_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .din      ((i == 0) ? s_tdata[ANGLE_W-1:0] : chain_sample[(i == 0) ? 0 : i-1]),
      .mm_in    (chain_mm[i]),
      .sample   (chain_sample[i]),
      .mm_out   (chain_mm[i+1])
    );
  end

  assign spread     = chain_mm[WINDOW].hi - chain_mm[WINDOW].lo;
  assign num        = NUM_W'(spread * SCALE);
  assign period_eff = (period == '0) ? PERIOD_W'(1) : period;

  always_comb begin
    if (s_tuser) begin
      count_next = COUNT_W'(1);
    end else if (count < COUNT_W'(WINDOW)) begin
      count_next = count + 1'b1;
    end else begin
      count_next = count;
    end
  end

  aws_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_MUL),
    .num      (num),
    .den      (den),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_W'(PERIOD_RST);
    end else if (cfg_we) begin
      period <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      scan     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            count <= count_next;
            scan  <= '0;
            state <= (count_next == COUNT_W'(WINDOW)) ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          scan <= scan + 1'b1;
          if (scan == SCAN_W'(WINDOW - 1)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      den           <= DEN_W'(WINDOW * period_eff);
      speed_r       <= '0;
      speed_valid_r <= (count_next == COUNT_W'(WINDOW));
    end else if (state == ST_DIV && div_done) begin
      speed_r <= (quotient > NUM_W'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX)
                                                 : quotient[SPEED_W-1:0];
    end
    if (state == ST_DONE && out_free) begin
      m_tdata <= {{(16 - SPEED_W){1'b0}}, speed_r};
      m_tuser <= speed_valid_r;
    end
  end

endmodule : angle_window_speed_top

`default_nettype wire

// File: design/aws_checker.sv
// Checker on the top level's ports, bound to the top level.
`default_nettype none

module aws_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tuser
);

  // One sample at a time: the input closes after each transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted in the cycle after a transfer");

  // A result without a full window carries zero speed.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 16'd0)
    else $error("speed nonzero while not valid");

  // Speed saturates within fifteen bits.
  a_saturated: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[15])
    else $error("speed beyond fifteen bits");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule : aws_checker

bind angle_window_speed_top aws_checker u_aws_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
